FILE: rtl/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types, codes and constants for the weather sample statistics block.
// ----------------------------------------------------------------------------
package wss_pkg;

  // Fixed field and state widths
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 24;
  localparam int CNT_W    = 8;
  localparam int IDX_W    = 3;
  localparam int MODE_W   = 2;
  localparam int QTY_W    = 2;
  localparam int OP_W     = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX        = 8'd255;
  localparam logic [CNT_W-1:0] GUST_SAMPLES_MAX = 8'd128;
  localparam int               GUST_WINDOW_DEF  = 6;
  localparam int               FIFO_DEPTH       = 4;

  // Input mode codes
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Quantity codes
  localparam logic [QTY_W-1:0] QTY_TEMP  = 2'd0;
  localparam logic [QTY_W-1:0] QTY_DIR   = 2'd1;
  localparam logic [QTY_W-1:0] QTY_SPEED = 2'd2;

  // Queued command codes
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Statistic index codes
  localparam logic [IDX_W-1:0] STAT_TEMP_MEAN  = 3'd0;
  localparam logic [IDX_W-1:0] STAT_TEMP_MAX   = 3'd1;
  localparam logic [IDX_W-1:0] STAT_TEMP_MIN   = 3'd2;
  localparam logic [IDX_W-1:0] STAT_DIR_MEAN   = 3'd3;
  localparam logic [IDX_W-1:0] STAT_SPEED_MEAN = 3'd4;
  localparam logic [IDX_W-1:0] STAT_GUST       = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic [QTY_W-1:0]           quantity;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]           stat_index;
    logic signed [SAMPLE_W-1:0] stat_value;
    logic                       stat_valid;
    logic                       last_of_read;
  } out_t;

  typedef struct packed {
    logic [OP_W-1:0]            op;
    logic [QTY_W-1:0]           quantity;
    logic signed [SAMPLE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                       start;
    logic signed [SUM_W-1:0]    dividend;
    logic [CNT_W-1:0]           divisor;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SUM_W-1:0]    quotient;
  } div_rsp_t;

endpackage

FILE: rtl/wss_front.sv
// ----------------------------------------------------------------------------
// wss_front
// Accepts input beats, decodes them into commands and drops the ones that
// carry an unknown mode or an add of an unknown quantity.
// ----------------------------------------------------------------------------
module wss_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  wss_pkg::in_t   in_data,
  output logic           push,
  output wss_pkg::cmd_t  push_cmd,
  input  logic           fifo_full
);

  logic          cmd_valid_r;
  wss_pkg::cmd_t cmd_r;
  logic          keep;
  wss_pkg::cmd_t dec_cmd;
  logic          accept;

  // Decode the incoming beat
  always_comb begin
    keep             = 1'b0;
    dec_cmd.op       = wss_pkg::OP_ADD;
    dec_cmd.quantity = in_data.quantity;
    dec_cmd.value    = in_data.sample_value;
    unique case (in_data.mode)
      wss_pkg::MODE_ADD: begin
        keep       = (in_data.quantity == wss_pkg::QTY_TEMP) ||
                     (in_data.quantity == wss_pkg::QTY_DIR) ||
                     (in_data.quantity == wss_pkg::QTY_SPEED);
        dec_cmd.op = wss_pkg::OP_ADD;
      end
      wss_pkg::MODE_READ: begin
        keep       = 1'b1;
        dec_cmd.op = wss_pkg::OP_READ;
      end
      wss_pkg::MODE_CLEAR: begin
        keep       = 1'b1;
        dec_cmd.op = wss_pkg::OP_CLEAR;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push     = cmd_valid_r && !fifo_full;
  assign push_cmd = cmd_r;
  assign in_stall = cmd_valid_r && fifo_full;
  assign accept   = in_valid && !in_stall;

  // Hold one decoded command until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else if (accept) begin
      cmd_valid_r <= keep;
    end else if (push) begin
      cmd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= dec_cmd;
    end
  end

endmodule

FILE: rtl/wss_fifo.sv
// ----------------------------------------------------------------------------
// wss_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module wss_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wss_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output wss_pkg::cmd_t  head,
  output logic           not_empty
);

  localparam int PTR_W = $clog2(wss_pkg::FIFO_DEPTH);

  wss_pkg::cmd_t    mem_r [wss_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full      = (count_r == (PTR_W+1)'(wss_pkg::FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/wss_div.sv
// ----------------------------------------------------------------------------
// wss_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module wss_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wss_pkg::div_req_t req,
  output wss_pkg::div_rsp_t rsp
);

  localparam int SUM_W  = wss_pkg::SUM_W;
  localparam int CNT_W  = wss_pkg::CNT_W;
  localparam int ITER_W = $clog2(SUM_W);

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [ITER_W-1:0] iter_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              ge;

  // Take the magnitude of the dividend
  assign mag    = req.dividend[SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;

  // One restoring step
  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && iter_r == ITER_W'(SUM_W-1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Load operands, then shift in one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r  <= mag;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
      neg_r  <= req.dividend[SUM_W-1];
      iter_r <= '0;
    end else if (busy_r) begin
      quo_r  <= {quo_r[SUM_W-2:0], ge};
      rem_r  <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      iter_r <= iter_r + 1'b1;
    end
  end

endmodule

FILE: rtl/wss_back.sv
// ----------------------------------------------------------------------------
// wss_back
// Executes queued commands: updates sums, extremes, counts and the gust
// window, and walks the six statistics of a read, dividing the three means
// on the shared serial divider.
// ----------------------------------------------------------------------------
module wss_back #(
  parameter int GUST_WINDOW = wss_pkg::GUST_WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  wss_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  output wss_pkg::div_req_t div_req,
  input  wss_pkg::div_rsp_t div_rsp,
  output logic              out_valid,
  input  logic              out_stall,
  output wss_pkg::out_t     out_data
);

  localparam int SAMPLE_W = wss_pkg::SAMPLE_W;
  localparam int SUM_W    = wss_pkg::SUM_W;
  localparam int CNT_W    = wss_pkg::CNT_W;
  localparam int IDX_W    = wss_pkg::IDX_W;
  localparam int WSUM_W   = SAMPLE_W + $clog2(GUST_WINDOW);

  // Gust divide by the window length as a reciprocal multiply; exact for
  // every window sum below 2^20 and window lengths up to 16
  localparam int                  RECIP_SH   = 24;
  localparam int                  PROD_W     = WSUM_W + RECIP_SH;
  localparam logic [RECIP_SH-1:0] GUST_RECIP =
    RECIP_SH'(((1 << RECIP_SH) + GUST_WINDOW - 1) / GUST_WINDOW);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  // Control
  logic [1:0]                 state_r;
  logic [IDX_W-1:0]           idx_r;
  logic signed [SAMPLE_W-1:0] val_r;
  logic                       vld_r;
  logic                       out_valid_r;
  wss_pkg::out_t              out_r;
  logic                       out_free;

  // Statistics state
  logic [CNT_W-1:0]           cnt_r      [3];
  logic [CNT_W-1:0]           cnt_nxt    [3];
  logic signed [SUM_W-1:0]    temp_sum_r,  temp_sum_nxt;
  logic signed [SAMPLE_W-1:0] temp_high_r, temp_high_nxt;
  logic signed [SAMPLE_W-1:0] temp_low_r,  temp_low_nxt;
  logic signed [SUM_W-1:0]    dir_sum_r,   dir_sum_nxt;
  logic signed [SUM_W-1:0]    speed_sum_r, speed_sum_nxt;
  logic signed [SAMPLE_W-1:0] dl_r       [GUST_WINDOW];
  logic signed [SAMPLE_W-1:0] dl_nxt     [GUST_WINDOW];
  logic signed [WSUM_W-1:0]   win_r,  win_nxt;
  logic signed [WSUM_W-1:0]   best_r, best_nxt;

  // Update helpers
  logic signed [SAMPLE_W-1:0] v;
  logic [CNT_W-1:0]           q_cnt;
  logic                       first;
  logic                       gust_full;
  logic signed [SAMPLE_W-1:0] oldest;
  logic signed [WSUM_W-1:0]   win_new;
  logic signed [WSUM_W-1:0]   best_base;

  // Read selection
  logic                       sel_valid;
  logic                       sel_div;
  logic signed [SAMPLE_W-1:0] sel_direct;
  logic signed [SUM_W-1:0]    sel_dividend;
  logic [CNT_W-1:0]           sel_divisor;
  logic [PROD_W-1:0]          gust_prod;
  logic signed [SAMPLE_W-1:0] gust_mean;

  assign v         = cmd.value;
  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid;
  assign q_cnt     = cnt_r[cmd.quantity];
  assign first     = (q_cnt == '0);
  assign gust_full = ({1'b0, q_cnt} + (CNT_W+1)'(1)) >= (CNT_W+1)'(GUST_WINDOW);

  // Compute next state for add and clear commands
  always_comb begin
    cnt_nxt       = cnt_r;
    temp_sum_nxt  = temp_sum_r;
    temp_high_nxt = temp_high_r;
    temp_low_nxt  = temp_low_r;
    dir_sum_nxt   = dir_sum_r;
    speed_sum_nxt = speed_sum_r;
    dl_nxt        = dl_r;
    win_nxt       = win_r;
    best_nxt      = best_r;
    oldest        = first ? '0 : dl_r[GUST_WINDOW-1];
    win_new       = (first ? '0 : win_r) + WSUM_W'(v) - WSUM_W'(oldest);
    best_base     = first ? '0 : best_r;
    if (cmd_pop) begin
      unique case (cmd.op)
        wss_pkg::OP_ADD: begin
          if (q_cnt != wss_pkg::COUNT_MAX) begin
            cnt_nxt[cmd.quantity] = q_cnt + 1'b1;
            unique case (cmd.quantity)
              wss_pkg::QTY_TEMP: begin
                if (first) begin
                  temp_sum_nxt  = SUM_W'(v);
                  temp_high_nxt = v;
                  temp_low_nxt  = v;
                end else begin
                  temp_sum_nxt  = temp_sum_r + SUM_W'(v);
                  temp_high_nxt = (v > temp_high_r) ? v : temp_high_r;
                  temp_low_nxt  = (v < temp_low_r) ? v : temp_low_r;
                end
              end
              wss_pkg::QTY_DIR: begin
                dir_sum_nxt = first ? SUM_W'(v) : dir_sum_r + SUM_W'(v);
              end
              wss_pkg::QTY_SPEED: begin
                speed_sum_nxt = first ? SUM_W'(v) : speed_sum_r + SUM_W'(v);
                // Shift the gust window while under the sample cap
                if (q_cnt < wss_pkg::GUST_SAMPLES_MAX) begin
                  dl_nxt[0] = v;
                  for (int i = 1; i < GUST_WINDOW; i++) begin
                    dl_nxt[i] = first ? '0 : dl_r[i-1];
                  end
                  win_nxt  = win_new;
                  best_nxt = (gust_full && win_new > best_base) ? win_new : best_base;
                end
              end
              default: ;
            endcase
          end
        end
        wss_pkg::OP_CLEAR: begin
          for (int i = 0; i < 3; i++) begin
            cnt_nxt[i] = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Scale the best window sum down to the gust; the best sum is never negative
  assign gust_prod = {{RECIP_SH{1'b0}}, best_r} * {{WSUM_W{1'b0}}, GUST_RECIP};
  assign gust_mean = gust_prod[RECIP_SH +: SAMPLE_W];

  // Select the operands of the current statistic
  always_comb begin
    sel_valid    = 1'b0;
    sel_div      = 1'b0;
    sel_direct   = '0;
    sel_dividend = '0;
    sel_divisor  = '0;
    unique case (idx_r)
      wss_pkg::STAT_TEMP_MEAN: begin
        sel_valid    = (cnt_r[wss_pkg::QTY_TEMP] != '0);
        sel_div      = 1'b1;
        sel_dividend = temp_sum_r;
        sel_divisor  = cnt_r[wss_pkg::QTY_TEMP];
      end
      wss_pkg::STAT_TEMP_MAX: begin
        sel_valid  = (cnt_r[wss_pkg::QTY_TEMP] != '0);
        sel_direct = temp_high_r;
      end
      wss_pkg::STAT_TEMP_MIN: begin
        sel_valid  = (cnt_r[wss_pkg::QTY_TEMP] != '0);
        sel_direct = temp_low_r;
      end
      wss_pkg::STAT_DIR_MEAN: begin
        sel_valid    = (cnt_r[wss_pkg::QTY_DIR] != '0);
        sel_div      = 1'b1;
        sel_dividend = dir_sum_r;
        sel_divisor  = cnt_r[wss_pkg::QTY_DIR];
      end
      wss_pkg::STAT_SPEED_MEAN: begin
        sel_valid    = (cnt_r[wss_pkg::QTY_SPEED] != '0);
        sel_div      = 1'b1;
        sel_dividend = speed_sum_r;
        sel_divisor  = cnt_r[wss_pkg::QTY_SPEED];
      end
      wss_pkg::STAT_GUST: begin
        sel_valid  = cnt_r[wss_pkg::QTY_SPEED] >= CNT_W'(GUST_WINDOW);
        sel_direct = gust_mean;
      end
      default: ;
    endcase
  end

  assign div_req.start    = (state_r == ST_PREP) && sel_valid && sel_div;
  assign div_req.dividend = sel_dividend;
  assign div_req.divisor  = sel_divisor;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Register the counts; clear them at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    temp_sum_r  <= temp_sum_nxt;
    temp_high_r <= temp_high_nxt;
    temp_low_r  <= temp_low_nxt;
    dir_sum_r   <= dir_sum_nxt;
    speed_sum_r <= speed_sum_nxt;
    dl_r        <= dl_nxt;
    win_r       <= win_nxt;
    best_r      <= best_nxt;
  end

  // Sequence the six statistics of a read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= wss_pkg::STAT_TEMP_MEAN;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_pop && cmd.op == wss_pkg::OP_READ) begin
            idx_r   <= wss_pkg::STAT_TEMP_MEAN;
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_r <= (sel_valid && sel_div) ? ST_DIV : ST_EMIT;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (idx_r == wss_pkg::STAT_GUST) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= ST_PREP;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Capture the statistic value
  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      vld_r <= sel_valid;
      val_r <= sel_valid ? sel_direct : '0;
    end else if (state_r == ST_DIV && div_rsp.done) begin
      val_r <= div_rsp.quotient[SAMPLE_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_r.stat_index   <= idx_r;
      out_r.stat_value   <= val_r;
      out_r.stat_valid   <= vld_r;
      out_r.last_of_read <= (idx_r == wss_pkg::STAT_GUST);
    end
  end

endmodule

FILE: rtl/weather_sample_statistics.sv
// ----------------------------------------------------------------------------
// weather_sample_statistics
// Running mean, extremes and gust statistics over tagged weather samples.
// ----------------------------------------------------------------------------
// Each input beat adds a sample, requests a read or clears the counts. A read
// returns six beats (temperature mean, max, min, direction mean, speed mean,
// gust), the last marked by last_of_read; a statistic without enough samples
// comes back with stat_valid low and value zero. The front decodes beats into
// a four-entry command queue, so the input keeps flowing until the queue is
// full while a read is being worked off. The back takes one command at a
// time: an add or clear is applied as it is popped, and after a read no new
// command is taken until all six beats are emitted. Each mean is set up,
// divided in the shared serial divider, which signals done, and then
// emitted; max, min and gust are set up and emitted, the gust coming from a
// reciprocal multiply. A mean without samples skips the divider. An output
// stall holds the emit step until the output is free.
// ----------------------------------------------------------------------------
module weather_sample_statistics #(
  parameter int GUST_WINDOW = wss_pkg::GUST_WINDOW_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  wss_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output wss_pkg::out_t out_data
);

  logic              push;
  wss_pkg::cmd_t     push_cmd;
  logic              fifo_full;
  logic              pop;
  wss_pkg::cmd_t     head;
  logic              not_empty;
  wss_pkg::div_req_t div_req;
  wss_pkg::div_rsp_t div_rsp;

  wss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_cmd  (push_cmd),
    .fifo_full (fifo_full)
  );

  wss_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  wss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  wss_back #(
    .GUST_WINDOW (GUST_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (not_empty),
    .cmd       (head),
    .cmd_pop   (pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
